// ===== rtl/ebp_pkg.sv =====
`default_nettype none

package ebp_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned HALF_W  = 16;
    localparam int unsigned PAD_W   = 33;
    localparam int unsigned STEP_W  = 5;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned OUT_W   = 216;

    typedef enum logic {
        ALU_DIV,
        ALU_MUL
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef enum logic [IDX_W-1:0] {
        REG_SYMBOL_LIMIT = 2'd0,
        REG_SYMBOL_BYTES = 2'd1,
        REG_OBJECT_BYTES = 2'd2
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== rtl/ebp_alu.sv =====
`default_nettype none

// Bit-serial unit: restoring divide (quotient in lo, remainder in hi) or
// shift-add multiply (product in {hi, lo}), one bit per cycle.
module ebp_alu
    import ebp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_alu_req          i_req,
    input  wire logic [WORD_W-1:0] i_a,
    input  wire logic [WORD_W-1:0] i_b,
    output logic                   o_done,
    output logic [WORD_W-1:0]      o_hi,
    output logic [WORD_W-1:0]      o_lo
);

    logic              r_busy;
    logic              r_done;
    t_alu_op           r_op;
    logic [STEP_W-1:0] r_cnt;
    logic [WORD_W-1:0] r_hi;
    logic [WORD_W-1:0] r_lo;
    logic [WORD_W-1:0] r_b;

    logic [WORD_W:0]   w_rem_sh;
    logic              w_ge;
    logic [WORD_W:0]   w_rem_sub;
    logic [WORD_W:0]   w_sum;

    always_comb begin
        w_rem_sh  = {r_hi, r_lo[WORD_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_b});
        w_rem_sub = w_rem_sh - {1'b0, r_b};
        w_sum     = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_b} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_op   <= i_req.op;
                r_hi   <= '0;
                r_lo   <= i_a;
                r_b    <= i_b;
            end else if (r_busy) begin
                unique case (r_op)
                    ALU_DIV: begin
                        r_hi <= w_ge ? w_rem_sub[WORD_W-1:0] : w_rem_sh[WORD_W-1:0];
                        r_lo <= {r_lo[WORD_W-2:0], w_ge};
                    end
                    ALU_MUL: begin
                        r_hi <= w_sum[WORD_W:1];
                        r_lo <= {w_sum[0], r_lo[WORD_W-1:1]};
                    end
                    default: begin
                        r_hi <= r_hi;
                    end
                endcase
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {STEP_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;

endmodule

`default_nettype wire

// ===== rtl/equal_block_partitioner.sv =====
`default_nettype none

// Equal block partitioner: answers geometry queries for an object that is
// cut into blocks of an equal number of symbols.
// Configuration: write symbol_limit (index 0), symbol_bytes (1) and
// object_bytes (2) through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Query channel (s_axis): one request carries a block number. Result
// channel (m_axis): one result per request; tuser flags a block past the end.
// Arithmetic: every division and multiplication runs on one bit-serial
// unit. A query costs (2 + E) divisions plus, for a block in range, three
// multiplications, E being the Euclid steps (1 to about 24). The sequencer
// over that unit sets the rate; one request is in work at a time and
// s_axis_tready is high only when idle.
// If any register is zero, the sequencer goes straight from S_IDLE to
// S_FINISH and the result has all fields zero; a block past the end is found
// after the block count division and also returns all fields zero.
// The result register holds a finished result while the receiver stalls;
// the next request is taken meanwhile and waits at its end for the slot.
// Reset sets all three registers to one and empties the result register.
module equal_block_partitioner
    import ebp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [WORD_W-1:0] i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [WORD_W-1:0] s_axis_tdata,   // block_number
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // symbols_each, block_bytes, offset_bytes, used_bytes, block_count,
    // symbol_count, padded_bytes, zero fill
    output logic [OUT_W-1:0]       m_axis_tdata,
    output logic                   m_axis_tuser    // out_of_range
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOTAL,
        S_GCD,
        S_GCD_WAIT,
        S_COUNT,
        S_RANGE,
        S_BSIZE,
        S_OFFSET,
        S_PAD,
        S_FINISH
    } t_state;

    t_state            r_state;

    logic [HALF_W-1:0] r_limit;
    logic [HALF_W-1:0] r_sym_bytes;
    logic [WORD_W-1:0] r_obj_bytes;

    logic [WORD_W-1:0] r_bn;
    logic              r_oor;
    logic [WORD_W-1:0] r_total;
    logic [WORD_W-1:0] r_ga;
    logic [WORD_W-1:0] r_gb;
    logic [HALF_W-1:0] r_each;
    logic [WORD_W-1:0] r_count;
    logic [WORD_W-1:0] r_bsize;
    logic [WORD_W-1:0] r_offset;
    logic [WORD_W-1:0] r_used;
    logic [PAD_W-1:0]  r_padded;

    t_alu_req          r_alu_req;
    logic [WORD_W-1:0] r_alu_a;
    logic [WORD_W-1:0] r_alu_b;
    logic              w_alu_done;
    logic [WORD_W-1:0] w_alu_hi;
    logic [WORD_W-1:0] w_alu_lo;

    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    logic              r_out_user;

    logic              w_accept;
    logic              w_zero_cfg;
    logic [WORD_W-1:0] w_remain;
    logic              w_slot_free;

    ebp_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_alu_req),
        .i_a     (r_alu_a),
        .i_b     (r_alu_b),
        .o_done  (w_alu_done),
        .o_hi    (w_alu_hi),
        .o_lo    (w_alu_lo)
    );

    always_comb begin
        w_accept    = s_axis_tvalid && (r_state == S_IDLE);
        w_zero_cfg  = (r_limit == '0) || (r_sym_bytes == '0) || (r_obj_bytes == '0);
        // offset never passes the last object byte for a valid block
        w_remain    = r_obj_bytes - w_alu_lo;
        w_slot_free = !r_out_valid || m_axis_tready;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= HALF_W'(1);
            r_sym_bytes <= HALF_W'(1);
            r_obj_bytes <= WORD_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SYMBOL_LIMIT: r_limit     <= i_cfg_data[HALF_W-1:0];
                REG_SYMBOL_BYTES: r_sym_bytes <= i_cfg_data[HALF_W-1:0];
                REG_OBJECT_BYTES: r_obj_bytes <= i_cfg_data;
                default:          r_limit     <= r_limit;
            endcase
        end
    end

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alu_req   <= '{start: 1'b0, op: ALU_DIV};
            r_out_valid <= 1'b0;
        end else begin
            // start is a one-cycle pulse; the wait states never issue again
            if (r_alu_req.start) begin
                r_alu_req.start <= 1'b0;
            end
            // S_FINISH reloads the slot itself when it drains
            if (r_out_valid && m_axis_tready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_bn  <= s_axis_tdata;
                        r_oor <= w_zero_cfg;
                        if (w_zero_cfg) begin
                            r_state <= S_FINISH;
                        end else begin
                            // symbol count = (object_bytes - 1) / symbol_bytes + 1
                            r_alu_req <= '{start: 1'b1, op: ALU_DIV};
                            r_alu_a   <= r_obj_bytes - 1'b1;
                            r_alu_b   <= {{(WORD_W-HALF_W){1'b0}}, r_sym_bytes};
                            r_state   <= S_TOTAL;
                        end
                    end
                end
                S_TOTAL: begin
                    if (w_alu_done) begin
                        r_total <= w_alu_lo + 1'b1;
                        r_ga    <= w_alu_lo + 1'b1;
                        r_gb    <= {{(WORD_W-HALF_W){1'b0}}, r_limit};
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_gb == '0) begin
                        // gcd found; it never exceeds symbol_limit
                        r_each    <= r_ga[HALF_W-1:0];
                        r_alu_req <= '{start: 1'b1, op: ALU_DIV};
                        r_alu_a   <= r_total;
                        r_alu_b   <= {{(WORD_W-HALF_W){1'b0}}, r_ga[HALF_W-1:0]};
                        r_state   <= S_COUNT;
                    end else begin
                        r_alu_req <= '{start: 1'b1, op: ALU_DIV};
                        r_alu_a   <= r_ga;
                        r_alu_b   <= r_gb;
                        r_state   <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT: begin
                    if (w_alu_done) begin
                        r_ga    <= r_gb;
                        r_gb    <= w_alu_hi;
                        r_state <= S_GCD;
                    end
                end
                S_COUNT: begin
                    if (w_alu_done) begin
                        r_count <= w_alu_lo;
                        r_state <= S_RANGE;
                    end
                end
                S_RANGE: begin
                    if (r_bn >= r_count) begin
                        r_oor   <= 1'b1;
                        r_state <= S_FINISH;
                    end else begin
                        r_alu_req <= '{start: 1'b1, op: ALU_MUL};
                        r_alu_a   <= {{(WORD_W-HALF_W){1'b0}}, r_each};
                        r_alu_b   <= {{(WORD_W-HALF_W){1'b0}}, r_sym_bytes};
                        r_state   <= S_BSIZE;
                    end
                end
                S_BSIZE: begin
                    if (w_alu_done) begin
                        r_bsize   <= w_alu_lo;
                        r_alu_req <= '{start: 1'b1, op: ALU_MUL};
                        r_alu_a   <= w_alu_lo;
                        r_alu_b   <= r_bn;
                        r_state   <= S_OFFSET;
                    end
                end
                S_OFFSET: begin
                    if (w_alu_done) begin
                        r_offset  <= w_alu_lo;
                        // clip the last block at the object end
                        r_used    <= (w_remain < r_bsize) ? w_remain : r_bsize;
                        r_alu_req <= '{start: 1'b1, op: ALU_MUL};
                        r_alu_a   <= r_total;
                        r_alu_b   <= {{(WORD_W-HALF_W){1'b0}}, r_sym_bytes};
                        r_state   <= S_PAD;
                    end
                end
                S_PAD: begin
                    if (w_alu_done) begin
                        r_padded <= {w_alu_hi[0], w_alu_lo};
                        r_state  <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    // hold until the result slot is free
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_user  <= r_oor;
                        if (r_oor) begin
                            r_out_data <= '0;
                        end else begin
                            r_out_data <= {{(OUT_W-HALF_W-5*WORD_W-PAD_W){1'b0}},
                                           r_padded, r_total, r_count, r_used,
                                           r_offset, r_bsize, r_each};
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== tb/equal_block_partitioner_check.sv =====
module equal_block_partitioner_check
    import ebp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [IDX_W-1:0]  i_cfg_idx,
    input  wire logic [WORD_W-1:0] i_cfg_data,
    input  wire logic              i_req_valid,
    input  wire logic              i_req_ready,
    input  wire logic [WORD_W-1:0] i_req_data,
    input  wire logic              i_res_valid,
    input  wire logic              i_res_ready,
    input  wire logic [OUT_W-1:0]  i_res_data,
    input  wire logic              i_res_flag,
    output int                     o_fail_count,
    output int                     o_pending,
    output logic [WORD_W-1:0]      o_block_count
);

    typedef struct packed {
        logic              out_of_range;
        logic [HALF_W-1:0] symbols_each;
        logic [WORD_W-1:0] block_bytes;
        logic [WORD_W-1:0] offset_bytes;
        logic [WORD_W-1:0] used_bytes;
        logic [WORD_W-1:0] block_count;
        logic [WORD_W-1:0] symbol_count;
        logic [PAD_W-1:0]  padded_bytes;
    } t_geometry;

    typedef struct packed {
        logic [WORD_W-1:0] block_number;
        t_geometry         geom;
    } t_pending_answer;

    logic [HALF_W-1:0] symbol_limit_q;
    logic [HALF_W-1:0] symbol_bytes_q;
    logic [WORD_W-1:0] object_bytes_q;

    t_pending_answer answer_q[$];
    int              fail_total = 0;
    t_geometry       first_block;

    function automatic logic [63:0] gcd_of(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        while (b != 64'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic t_geometry plan_block(
        input logic [WORD_W-1:0] bn,
        input logic [HALF_W-1:0] lim,
        input logic [HALF_W-1:0] sb,
        input logic [WORD_W-1:0] ob
    );
        logic [63:0] total;
        logic [63:0] each;
        logic [63:0] count;
        logic [63:0] bsize;
        logic [63:0] offset;
        logic [63:0] remain;
        logic [63:0] padded;
        t_geometry   g;
        total = 64'd0;
        each  = 64'd0;
        count = 64'd0;
        g     = '0;
        if (lim != 0 && sb != 0 && ob != 0) begin
            total = ((64'(ob) - 64'd1) / 64'(sb)) + 64'd1;
            each  = gcd_of(total, 64'(lim));
            count = total / each;
        end
        if (64'(bn) >= count) begin
            g.out_of_range = 1'b1;
            return g;
        end
        bsize  = each * 64'(sb);
        offset = bsize * 64'(bn);
        remain = 64'(ob) - offset;
        padded = total * 64'(sb);
        g.symbols_each = each[HALF_W-1:0];
        g.block_bytes  = bsize[WORD_W-1:0];
        g.offset_bytes = offset[WORD_W-1:0];
        g.used_bytes   = (remain < bsize) ? remain[WORD_W-1:0] : bsize[WORD_W-1:0];
        g.block_count  = count[WORD_W-1:0];
        g.symbol_count = total[WORD_W-1:0];
        g.padded_bytes = padded[PAD_W-1:0];
        return g;
    endfunction

    task automatic flag_mismatch(input string msg);
        fail_total++;
        $display("mismatch: %s", msg);
    endtask

    task automatic check_field(
        input string             name,
        input logic [WORD_W-1:0] bn,
        input logic [63:0]       got,
        input logic [63:0]       want
    );
        if (got !== want)
            flag_mismatch($sformatf("block %0d %s got %0h want %0h", bn, name, got, want));
    endtask

    // block 0 gives the block count of the current setting, or zero if none
    always_comb begin
        first_block = plan_block('0, symbol_limit_q, symbol_bytes_q, object_bytes_q);
    end
    assign o_block_count = first_block.block_count;
    assign o_fail_count  = fail_total;

    always @(posedge i_clk) begin : watch
        t_pending_answer want;
        t_geometry       got;
        if (!i_rst_n) begin
            symbol_limit_q <= 16'd1;
            symbol_bytes_q <= 16'd1;
            object_bytes_q <= 32'd1;
            o_pending      <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SYMBOL_LIMIT: symbol_limit_q <= i_cfg_data[HALF_W-1:0];
                    REG_SYMBOL_BYTES: symbol_bytes_q <= i_cfg_data[HALF_W-1:0];
                    REG_OBJECT_BYTES: object_bytes_q <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res_valid && i_res_ready) begin
                if (answer_q.size() == 0) begin
                    flag_mismatch("result with no request waiting");
                end else begin
                    want = answer_q.pop_front();
                    got.out_of_range = i_res_flag;
                    got.symbols_each = i_res_data[15:0];
                    got.block_bytes  = i_res_data[47:16];
                    got.offset_bytes = i_res_data[79:48];
                    got.used_bytes   = i_res_data[111:80];
                    got.block_count  = i_res_data[143:112];
                    got.symbol_count = i_res_data[175:144];
                    got.padded_bytes = i_res_data[208:176];
                    check_field("out_of_range", want.block_number,
                                64'(got.out_of_range), 64'(want.geom.out_of_range));
                    check_field("symbols_each", want.block_number,
                                64'(got.symbols_each), 64'(want.geom.symbols_each));
                    check_field("block_bytes", want.block_number,
                                64'(got.block_bytes), 64'(want.geom.block_bytes));
                    check_field("offset_bytes", want.block_number,
                                64'(got.offset_bytes), 64'(want.geom.offset_bytes));
                    check_field("used_bytes", want.block_number,
                                64'(got.used_bytes), 64'(want.geom.used_bytes));
                    check_field("block_count", want.block_number,
                                64'(got.block_count), 64'(want.geom.block_count));
                    check_field("symbol_count", want.block_number,
                                64'(got.symbol_count), 64'(want.geom.symbol_count));
                    check_field("padded_bytes", want.block_number,
                                64'(got.padded_bytes), 64'(want.geom.padded_bytes));
                    check_field("zero fill", want.block_number,
                                64'(i_res_data[OUT_W-1:209]), 64'd0);
                end
            end
            if (i_req_valid && i_req_ready) begin
                want.block_number = i_req_data;
                want.geom = plan_block(i_req_data, symbol_limit_q, symbol_bytes_q,
                                       object_bytes_q);
                answer_q.push_back(want);
            end
            o_pending <= answer_q.size();
        end
    end

endmodule

// ===== tb/equal_block_partitioner_test.sv =====
module equal_block_partitioner_test;
    import ebp_pkg::*;

    // Run limit: some 540 requests of serial divide and multiply, idle gaps on
    // each side and one long receiver hold-off; allow 30M time units before
    // calling the run hung.
    localparam int unsigned LIMIT_TIME   = 30_000_000;
    localparam int unsigned HOLD_CYCLES  = 3000;
    localparam int unsigned RAND_PHASES  = 20;
    localparam int unsigned PHASE_ITEMS  = 26;
    // index past the register list: the block must ignore it
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx     = '0;
    logic [WORD_W-1:0] i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [WORD_W-1:0] s_axis_tdata  = '0;     // block_number
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // symbols_each, block_bytes, offset_bytes, used_bytes, block_count,
    // symbol_count, padded_bytes, zero fill
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;           // out_of_range

    int                fail_count;
    int                pending;
    logic [WORD_W-1:0] blocks_now;

    // idling controls shared between the stimulus and the receiver
    bit tx_idle_on  = 1'b0;
    bit rx_idle_on  = 1'b0;
    bit rx_hold_req = 1'b0;

    equal_block_partitioner u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    equal_block_partitioner_check u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_flag    (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_block_count (blocks_now)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(LIMIT_TIME);
        $display("equal_block_partitioner regression: fail");
        $finish;
    end

    // Receiver: random stall bursts, or one long hold-off when asked for.
    // The hold-off lets a finished result sit in the output register while
    // the next request completes behind it, so the input side must stall.
    initial begin
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Write one register; the caller lowers the write enable after its
    // last write so back-to-back writes keep it high.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    task automatic load_config(
        input logic [WORD_W-1:0] limit_word,
        input logic [WORD_W-1:0] sbytes_word,
        input logic [WORD_W-1:0] obytes_word
    );
        write_reg(REG_SYMBOL_LIMIT, limit_word);
        write_reg(REG_SYMBOL_BYTES, sbytes_word);
        write_reg(REG_OBJECT_BYTES, obytes_word);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one request and hold it until taken. Keep tvalid high when the
    // next request follows at once; drop it only for a real gap.
    task automatic offer_block(input logic [WORD_W-1:0] bn);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (tx_idle_on && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Drop the request line and wait until every answer is back.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic pick_config();
        logic [WORD_W-1:0] noise;
        logic [HALF_W-1:0] lim;
        logic [HALF_W-1:0] sb;
        logic [WORD_W-1:0] ob;
        noise = $urandom;
        case ($urandom_range(0, 19))
            0:          lim = 16'd0;
            1, 2, 3, 4: lim = HALF_W'($urandom_range(1, 16));
            5:          lim = 16'hFFFF;
            default:    lim = HALF_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 19))
            0:          sb = 16'd0;
            1, 2, 3, 4: sb = HALF_W'($urandom_range(1, 16));
            5:          sb = 16'hFFFF;
            default:    sb = HALF_W'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 19))
            0:                  ob = 32'd0;
            1:                  ob = 32'hFFFF_FFFF;
            2, 3, 4, 5, 6, 7:   ob = $urandom_range(1, 4096);
            default:            ob = $urandom;
        endcase
        // junk in the upper half of the words for the 16-bit registers must be masked off
        load_config({noise[31:16], lim}, {noise[15:0], sb}, ob);
    endtask

    // Aim mostly at real blocks, with the first one, the last one, the first four
    // numbers past the end and arbitrary numbers mixed in.
    function automatic logic [WORD_W-1:0] pick_block(input logic [WORD_W-1:0] count);
        logic [WORD_W-1:0] r;
        r = $urandom;
        if (count == 0)
            return r;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return count - 1;
            2:       return count + $urandom_range(0, 3);
            3:       return r;
            default: return r % count;
        endcase
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset setting (1, 1, 1): one block of one byte.
        offer_block(32'd0);
        offer_block(32'd1);
        offer_block(32'hFFFF_FFFF);
        drain();

        // Long receiver hold-off with back-to-back requests: fill the
        // output register and the sequencer, then stall the input.
        rx_hold_req = 1'b1;
        repeat (10) @(posedge i_clk);
        offer_block(32'd0);
        offer_block(32'd0);
        offer_block(32'd1);
        offer_block(32'd0);
        drain();

        // Largest everything: 65537 symbols, one per block.
        load_config(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
        offer_block(32'd0);
        offer_block(32'd65536);
        offer_block(32'd65537);
        drain();

        // One-byte symbols over the largest object: full-limit blocks.
        load_config(32'h0000_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
        offer_block(32'd0);
        offer_block(32'd65536);
        offer_block(32'd65537);
        drain();

        // Masked writes plus a write to the unused index; the last block
        // is clipped at the object end.
        load_config(32'hFFFF_000D, 32'h1234_0007, 32'd1000);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        offer_block(32'd0);
        offer_block(32'd10);
        offer_block(32'd11);
        drain();

        // Any zero register: no blocks at all.
        load_config(32'd0, 32'd7, 32'd1000);
        offer_block(32'd0);
        drain();
        load_config(32'd13, 32'd0, 32'd1000);
        offer_block(32'd0);
        drain();
        load_config(32'd13, 32'd7, 32'd0);
        offer_block(32'd0);
        drain();

        // Symbol larger than the object.
        load_config(32'h0000_FFFF, 32'h0000_FFFF, 32'd1);
        offer_block(32'd0);
        offer_block(32'd1);
        drain();

        // Random settings; every fourth phase runs without idling, and the
        // closing phases run flat out.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            pick_config();
            tx_idle_on = (phase % 4 != 1) && (phase < RAND_PHASES - 3);
            rx_idle_on = tx_idle_on;
            for (int n = 0; n < PHASE_ITEMS; n++)
                offer_block(pick_block(blocks_now));
            drain();
        end

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("equal_block_partitioner regression: pass");
        end else begin
            $display("equal_block_partitioner regression: fail");
        end
        $finish;
    end

endmodule
